/* hw/rtl/doubly_linked_node_list_assert.svh */
// Assertion helpers for the linked node list. Both expect clk and rst_n in scope.
`ifndef DOUBLY_LINKED_NODE_LIST_ASSERT_SVH
`define DOUBLY_LINKED_NODE_LIST_ASSERT_SVH

// Same-cycle implication.
`define DLNL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlnl check failed");

// Next-cycle implication.
`define DLNL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlnl check failed");

`endif

/* hw/rtl/dlnl_pkg.sv */
package dlnl_pkg;

    localparam int NODE_W         = 8;
    localparam int POOL_NODES_DEF = 256;

    typedef enum logic [1:0] {
        MODE_APPEND    = 2'd0,
        MODE_ERASE     = 2'd1,
        MODE_TAKE_HEAD = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_PUSH_MEMBER  = 2'd1,
        ST_ERASE_ABSENT = 2'd2,
        ST_POP_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        mode_t             mode;
        logic [NODE_W-1:0] node;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] removed_node;
        logic [NODE_W-1:0] head_node;
        logic [NODE_W-1:0] tail_node;
        logic              is_empty;
    } res_t;

    // Microprogram addresses.
    typedef enum logic [2:0] {
        STEP_FETCH      = 3'd0,
        STEP_PUSH       = 3'd1,
        STEP_UNLINK     = 3'd2,
        STEP_REJ_PUSH   = 3'd3,
        STEP_REJ_ERASE  = 3'd4,
        STEP_POP_EMPTY  = 3'd5,
        STEP_NOP        = 3'd6
    } step_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_LATCH  = 2'd1,
        ACT_PUSH   = 2'd2,
        ACT_UNLINK = 2'd3
    } act_t;

    // SEQ_DISPATCH: wait for a word, then jump by decoded class.
    // SEQ_RETURN: back to fetch once the result is written.
    typedef enum logic {
        SEQ_DISPATCH = 1'b0,
        SEQ_RETURN   = 1'b1
    } seq_t;

    typedef struct packed {
        act_t    act;
        logic    emit;
        status_t status;
        seq_t    seq;
    } uword_t;

    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        unique case (s)
            STEP_FETCH:     w = '{act: ACT_LATCH,  emit: 1'b0, status: ST_DONE,
                                  seq: SEQ_DISPATCH};
            STEP_PUSH:      w = '{act: ACT_PUSH,   emit: 1'b1, status: ST_DONE,
                                  seq: SEQ_RETURN};
            STEP_UNLINK:    w = '{act: ACT_UNLINK, emit: 1'b1, status: ST_DONE,
                                  seq: SEQ_RETURN};
            STEP_REJ_PUSH:  w = '{act: ACT_NONE,   emit: 1'b1, status: ST_PUSH_MEMBER,
                                  seq: SEQ_RETURN};
            STEP_REJ_ERASE: w = '{act: ACT_NONE,   emit: 1'b1, status: ST_ERASE_ABSENT,
                                  seq: SEQ_RETURN};
            STEP_POP_EMPTY: w = '{act: ACT_NONE,   emit: 1'b1, status: ST_POP_EMPTY,
                                  seq: SEQ_RETURN};
            STEP_NOP:       w = '{act: ACT_NONE,   emit: 1'b1, status: ST_DONE,
                                  seq: SEQ_RETURN};
            default:        w = '{act: ACT_NONE,   emit: 1'b0, status: ST_DONE,
                                  seq: SEQ_RETURN};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/dlnl_ram.sv */
module dlnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

/* hw/rtl/doubly_linked_node_list.sv */
// Insertion-ordered doubly linked list over a pool of POOL_NODES node indices.
// Each cmd word is an append, an erase or a take-head of a node; each produces exactly
// one res word with status, removed node, new head/tail and an empty flag.
// Other modes change nothing but still get a res word. The fetch step accepts
// the word, decodes it against the membership flags and issues the read of the
// node's prev/next links; the dispatched microcode step consumes the registered
// link data, rewrites at most one prev and one next entry and loads the result
// register. The link RAM read is registered, so the update needs a step of its
// own. While the result register holds an untaken word the update step waits;
// cmd_stall is high whenever the sequencer is not in its fetch step. Link RAMs
// are never cleared: a link is only followed where an earlier push or splice wrote it.
// Membership flags sit in flops and clear at reset.
`include "doubly_linked_node_list_assert.svh"

module doubly_linked_node_list #(
    parameter int POOL_NODES = dlnl_pkg::POOL_NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  dlnl_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output dlnl_pkg::res_t res
);

    // Only indices the node field can reach need storage.
    localparam int LINK_DEPTH = (POOL_NODES < (1 << dlnl_pkg::NODE_W)) ?
                                POOL_NODES : (1 << dlnl_pkg::NODE_W);
    localparam int AW         = $clog2(LINK_DEPTH);

    // Sequencer
    dlnl_pkg::step_t  step_reg, step_next;
    dlnl_pkg::step_t  dispatch_step;
    dlnl_pkg::uword_t uw;

    // List state
    logic [dlnl_pkg::NODE_W-1:0] head_reg, head_next;
    logic [dlnl_pkg::NODE_W-1:0] tail_reg, tail_next;
    logic                        occ_reg, occ_next;
    logic [LINK_DEPTH-1:0]       member_reg;
    logic                        mem_set, mem_clr;

    // Datapath
    logic [dlnl_pkg::NODE_W-1:0] target_reg, fetch_target, rd_node;
    logic [dlnl_pkg::NODE_W-1:0] prev_rd, next_rd;
    logic                        prev_we, next_we;
    logic [AW-1:0]               prev_waddr, next_waddr;
    logic [dlnl_pkg::NODE_W-1:0] prev_wdata, next_wdata;
    logic                        node_in_pool, node_member;
    logic                        is_head, is_tail;

    // Result register
    logic           res_valid_reg;
    dlnl_pkg::res_t res_reg, res_next;
    logic           res_free, advance, cmd_take;

    assign uw        = dlnl_pkg::ucode_rom(step_reg);
    assign cmd_stall = (step_reg != dlnl_pkg::STEP_FETCH);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    // An emitting step stalls in place until the result slot frees up.
    assign advance   = !uw.emit || res_free;

    // Decode of the incoming word against membership.
    assign node_in_pool = (32'(cmd.node) < 32'(POOL_NODES));
    assign node_member  = node_in_pool && member_reg[cmd.node[AW-1:0]];
    // Take-head works on the current head; erase and append on the given node.
    assign fetch_target = (cmd.mode == dlnl_pkg::MODE_TAKE_HEAD) ? head_reg : cmd.node;

    always_comb
    begin
        unique case (cmd.mode)
            dlnl_pkg::MODE_APPEND:
                dispatch_step = (!node_in_pool || node_member) ?
                                dlnl_pkg::STEP_REJ_PUSH : dlnl_pkg::STEP_PUSH;
            dlnl_pkg::MODE_ERASE:
                dispatch_step = node_member ?
                                dlnl_pkg::STEP_UNLINK : dlnl_pkg::STEP_REJ_ERASE;
            dlnl_pkg::MODE_TAKE_HEAD:
                dispatch_step = occ_reg ?
                                dlnl_pkg::STEP_UNLINK : dlnl_pkg::STEP_POP_EMPTY;
            default:
                dispatch_step = dlnl_pkg::STEP_NOP;
        endcase
    end

    // Next step
    always_comb
    begin
        unique case (uw.seq)
            dlnl_pkg::SEQ_DISPATCH: step_next = cmd_valid ? dispatch_step : step_reg;
            dlnl_pkg::SEQ_RETURN:   step_next = advance ? dlnl_pkg::STEP_FETCH : step_reg;
            default:                step_next = dlnl_pkg::STEP_FETCH;
        endcase
    end

    // Link reads: issued from the incoming word during fetch, then held on the
    // latched target so the data survives a stalled update step.
    assign rd_node = cmd_stall ? target_reg : fetch_target;

    dlnl_ram #(
        .WIDTH (dlnl_pkg::NODE_W),
        .DEPTH (LINK_DEPTH)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_node[AW-1:0]),
        .rdata (prev_rd)
    );

    dlnl_ram #(
        .WIDTH (dlnl_pkg::NODE_W),
        .DEPTH (LINK_DEPTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_node[AW-1:0]),
        .rdata (next_rd)
    );

    assign is_head = (target_reg == head_reg);
    assign is_tail = (target_reg == tail_reg);

    // Control word outputs: the datapath actions of the current step.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        mem_set    = 1'b0;
        mem_clr    = 1'b0;
        prev_we    = 1'b0;
        next_we    = 1'b0;
        prev_waddr = target_reg[AW-1:0];
        next_waddr = tail_reg[AW-1:0];
        prev_wdata = tail_reg;
        next_wdata = target_reg;

        case (uw.act)
            dlnl_pkg::ACT_PUSH:
            begin
                if (advance)
                begin
                    mem_set = 1'b1;
                    if (occ_reg)
                    begin
                        // old tail -> new node, new node <- old tail
                        next_we   = 1'b1;
                        prev_we   = 1'b1;
                        tail_next = target_reg;
                    end
                    else
                    begin
                        head_next = target_reg;
                        tail_next = target_reg;
                        occ_next  = 1'b1;
                    end
                end
            end
            dlnl_pkg::ACT_UNLINK:
            begin
                if (advance)
                begin
                    mem_clr = 1'b1;
                    if (is_head && is_tail)
                    begin
                        occ_next  = 1'b0;
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (is_head)
                    begin
                        head_next = next_rd;
                    end
                    else if (is_tail)
                    begin
                        tail_next = prev_rd;
                    end
                    else
                    begin
                        // middle node: splice its neighbors together
                        next_we    = 1'b1;
                        next_waddr = prev_rd[AW-1:0];
                        next_wdata = next_rd;
                        prev_we    = 1'b1;
                        prev_waddr = next_rd[AW-1:0];
                        prev_wdata = prev_rd;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res_next.status       = uw.status;
        res_next.removed_node = (uw.act == dlnl_pkg::ACT_UNLINK) ? target_reg : '0;
        res_next.head_node    = occ_next ? head_next : '0;
        res_next.tail_node    = occ_next ? tail_next : '0;
        res_next.is_empty     = !occ_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= dlnl_pkg::STEP_FETCH;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= 1'b0;
            member_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            if (mem_set)
            begin
                member_reg[target_reg[AW-1:0]] <= 1'b1;
            end
            else if (mem_clr)
            begin
                member_reg[target_reg[AW-1:0]] <= 1'b0;
            end
            if (uw.emit && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            target_reg <= fetch_target;
        end
        if (uw.emit && res_free)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Empty list keeps both ends at zero.
    `DLNL_ASSERT_NOW(a_empty_ends_zero, !occ_reg, (head_reg == '0) && (tail_reg == '0))
    // Both ends of a non-empty list are members.
    `DLNL_ASSERT_NOW(a_ends_member, occ_reg,
        member_reg[head_reg[AW-1:0]] && member_reg[tail_reg[AW-1:0]])
    // Unlink only ever works on a member node.
    `DLNL_ASSERT_NOW(a_unlink_member, step_reg == dlnl_pkg::STEP_UNLINK,
        member_reg[target_reg[AW-1:0]])
    // A word accepted at fetch always leads into a work step.
    `DLNL_ASSERT_NXT(a_fetch_leaves, cmd_take, step_reg != dlnl_pkg::STEP_FETCH)

endmodule

/* dv/doubly_linked_node_list_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the list and checks every res word.
module doubly_linked_node_list_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  dlnl_pkg::cmd_t cmd,
    input  logic           res_valid,
    input  logic           res_stall,
    input  dlnl_pkg::res_t res,
    output int             fail_count,
    output int             pending
);

    logic [dlnl_pkg::NODE_W-1:0] prev_of [dlnl_pkg::POOL_NODES_DEF];
    logic [dlnl_pkg::NODE_W-1:0] next_of [dlnl_pkg::POOL_NODES_DEF];
    bit                          in_list [dlnl_pkg::POOL_NODES_DEF];
    logic [dlnl_pkg::NODE_W-1:0] front = '0;
    logic [dlnl_pkg::NODE_W-1:0] back  = '0;
    bit                          occupied = 1'b0;

    dlnl_pkg::res_t awaited_res[$];
    int             mismatches = 0;

    // Ends are never followed, so moving the head or tail leaves the stale link alone.
    function automatic void detach(logic [dlnl_pkg::NODE_W-1:0] n);
        logic [dlnl_pkg::NODE_W-1:0] p;
        logic [dlnl_pkg::NODE_W-1:0] q;
        p = prev_of[n];
        q = next_of[n];
        if (n == front && n == back)
        begin
            occupied = 1'b0;
            front    = '0;
            back     = '0;
        end
        else if (n == front)
        begin
            front = q;
        end
        else if (n == back)
        begin
            back = p;
        end
        else
        begin
            next_of[p] = q;
            prev_of[q] = p;
        end
        prev_of[n] = '0;
        next_of[n] = '0;
        in_list[n] = 1'b0;
    endfunction

    function automatic dlnl_pkg::res_t apply_cmd(dlnl_pkg::cmd_t c);
        dlnl_pkg::res_t r;
        r = '0;
        case (c.mode)
            dlnl_pkg::MODE_APPEND:
            begin
                if (in_list[c.node])
                begin
                    r.status = dlnl_pkg::ST_PUSH_MEMBER;
                end
                else
                begin
                    prev_of[c.node] = '0;
                    next_of[c.node] = '0;
                    if (!occupied)
                    begin
                        front    = c.node;
                        back     = c.node;
                        occupied = 1'b1;
                    end
                    else
                    begin
                        next_of[back]   = c.node;
                        prev_of[c.node] = back;
                        back            = c.node;
                    end
                    in_list[c.node] = 1'b1;
                end
            end
            dlnl_pkg::MODE_ERASE:
            begin
                if (!in_list[c.node])
                begin
                    r.status = dlnl_pkg::ST_ERASE_ABSENT;
                end
                else
                begin
                    detach(c.node);
                    r.removed_node = c.node;
                end
            end
            dlnl_pkg::MODE_TAKE_HEAD:
            begin
                if (!occupied)
                begin
                    r.status = dlnl_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    r.removed_node = front;
                    detach(front);
                end
            end
            default:
            begin
                // unused mode: no change, ends reported as they stand
            end
        endcase
        r.head_node = occupied ? front : '0;
        r.tail_node = occupied ? back : '0;
        r.is_empty  = !occupied;
        return r;
    endfunction

    function automatic void check_field(string label, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        dlnl_pkg::res_t want;
        if (rst_n === 1'b1)
        begin
            // Result first: a res word can never belong to the cmd word of the same edge.
            if (res_valid === 1'b1 && res_stall === 1'b0)
            begin
                if (awaited_res.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: res word with none expected: expected nothing, actual %h",
                             $time, res);
                end
                else
                begin
                    want = awaited_res[0];
                    awaited_res.delete(0);
                    check_field("status", want.status, res.status);
                    check_field("removed_node", want.removed_node, res.removed_node);
                    check_field("head_node", want.head_node, res.head_node);
                    check_field("tail_node", want.tail_node, res.tail_node);
                    check_field("is_empty", want.is_empty, res.is_empty);
                end
            end
            if (cmd_valid === 1'b1 && cmd_stall === 1'b0)
                awaited_res.insert(awaited_res.size(), apply_cmd(cmd));
        end
        fail_count <= mismatches;
        pending    <= awaited_res.size();
    end

endmodule

/* dv/tb_doubly_linked_node_list.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the linked node list; checking lives in the checker.
module tb_doubly_linked_node_list;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;   // no-op mode, no enum member
    localparam int         RANDOM_WORDS = 800;
    localparam int         MAX_GAP      = 5;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         STUCK_LIMIT  = 500;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    dlnl_pkg::cmd_t cmd       = '0;
    logic           res_valid;
    logic           res_stall = 1'b0;
    dlnl_pkg::res_t res;

    int fail_count;
    int pending;
    int stuck_cycles = 0;

    // Set during some stretches of the random part: both sides run with no idling.
    bit quiet = 1'b0;

    // Shadow of list membership, used only to steer stimulus toward members.
    logic [7:0] live_nodes[$];
    bit         live_flag[256];

    doubly_linked_node_list uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    doubly_linked_node_list_checker list_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sends one cmd word after a random gap and returns at the edge that takes it.
    // valid gets at most one NBA per step: lowered only when a gap is drawn.
    task automatic issue(input logic [1:0] op, input logic [7:0] n);
        int gap;
        int i;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{mode: dlnl_pkg::mode_t'(op), node: n};
        do @(posedge clk); while (cmd_stall !== 1'b0);

        // Track membership in issue order, which is the order the block applies them.
        if (op == dlnl_pkg::MODE_APPEND && !live_flag[n])
        begin
            live_nodes.insert(live_nodes.size(), n);
            live_flag[n] = 1'b1;
        end
        else if (op == dlnl_pkg::MODE_ERASE && live_flag[n])
        begin
            for (i = 0; i < live_nodes.size(); i++)
            begin
                if (live_nodes[i] == n)
                begin
                    live_nodes.delete(i);
                    break;
                end
            end
            live_flag[n] = 1'b0;
        end
        else if (op == dlnl_pkg::MODE_TAKE_HEAD && live_nodes.size() > 0)
        begin
            live_flag[live_nodes[0]] = 1'b0;
            live_nodes.delete(0);
        end
    endtask

    // Mostly well-formed traffic: fresh appends, erases of real members at any
    // position, head removals. The rest is noise: duplicate appends, erases of
    // absent nodes, head removals on empty and the unused mode. Mix drifts the
    // list size between empty and a couple dozen nodes.
    task automatic issue_random();
        int         roll;
        int         sz;
        int         push_pct;
        int         erase_pct;
        logic [7:0] n;
        sz   = live_nodes.size();
        roll = $urandom_range(0, 99);
        if (sz < 4)
        begin
            push_pct  = 60;
            erase_pct = 20;
        end
        else if (sz > 24)
        begin
            push_pct  = 25;
            erase_pct = 40;
        end
        else
        begin
            push_pct  = 42;
            erase_pct = 32;
        end

        if (roll < 3)
        begin
            issue(MODE_UNUSED, 8'($urandom));
        end
        else if (roll < 3 + push_pct)
        begin
            // narrow range now and then to force duplicate appends
            n = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            issue(dlnl_pkg::MODE_APPEND, n);
        end
        else if (roll < 3 + push_pct + erase_pct)
        begin
            if (sz > 0 && $urandom_range(0, 4) != 0)
                n = live_nodes[$urandom_range(0, sz - 1)];
            else
                n = 8'($urandom);
            issue(dlnl_pkg::MODE_ERASE, n);
        end
        else
        begin
            issue(dlnl_pkg::MODE_TAKE_HEAD, 8'($urandom));
        end
    endtask

    // Receiver: random stall before each res word, none in quiet stretches.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                res_stall <= 1'b0;
            end
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    // Watchdog: too many cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every mode, each erase shape, empty-list cases.
        issue(dlnl_pkg::MODE_APPEND, 8'd0);       // first node into empty list
        issue(dlnl_pkg::MODE_APPEND, 8'd255);     // top index
        issue(dlnl_pkg::MODE_APPEND, 8'd0);       // already a member
        issue(dlnl_pkg::MODE_ERASE, 8'd7);        // never a member
        issue(dlnl_pkg::MODE_TAKE_HEAD, 8'd0);    // removes 0, head moves to 255
        issue(dlnl_pkg::MODE_ERASE, 8'd255);      // only node, list empties
        issue(dlnl_pkg::MODE_TAKE_HEAD, 8'd255);  // head removal on empty
        issue(dlnl_pkg::MODE_ERASE, 8'd255);      // erase on empty
        issue(MODE_UNUSED, 8'd255);               // unused mode on empty list
        issue(dlnl_pkg::MODE_APPEND, 8'd1);
        issue(dlnl_pkg::MODE_APPEND, 8'd2);
        issue(dlnl_pkg::MODE_APPEND, 8'd3);
        issue(dlnl_pkg::MODE_APPEND, 8'd4);
        issue(dlnl_pkg::MODE_ERASE, 8'd3);        // middle node
        issue(dlnl_pkg::MODE_ERASE, 8'd1);        // head
        issue(dlnl_pkg::MODE_ERASE, 8'd4);        // tail
        issue(MODE_UNUSED, 8'd0);                 // unused mode with a live list
        issue(dlnl_pkg::MODE_APPEND, 8'd4);       // reuse of an erased node
        issue(dlnl_pkg::MODE_TAKE_HEAD, 8'd0);
        issue(dlnl_pkg::MODE_TAKE_HEAD, 8'd0);    // back to empty
        issue(dlnl_pkg::MODE_APPEND, 8'd170);     // alternating bit patterns
        issue(dlnl_pkg::MODE_APPEND, 8'd85);
        issue(dlnl_pkg::MODE_ERASE, 8'd85);
        issue(dlnl_pkg::MODE_TAKE_HEAD, 8'd0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet = ((i / 100) % 4) == 3;
            issue_random();
        end
        cmd_valid <= 1'b0;
        quiet = 1'b0;

        // pending is registered in the checker, so let it settle before polling it
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dlnl_pkg.sv
hw/rtl/dlnl_ram.sv
hw/rtl/doubly_linked_node_list.sv
dv/doubly_linked_node_list_checker.sv
dv/tb_doubly_linked_node_list.sv
